// File: rtl/mtep_pkg.sv
// Package for the track event parser: parse phase encoding, result kind codes,
// status and meta type constants, and the packed result word layout.
// No dependencies.
package mtep_pkg;

  // Parse phase, one-hot.
  typedef enum logic [8:0] {
    PH_DELTA  = 9'b000000001,
    PH_STATUS = 9'b000000010,
    PH_DATA1  = 9'b000000100,
    PH_DATA2  = 9'b000001000,
    PH_MTYPE  = 9'b000010000,
    PH_MLEN   = 9'b000100000,
    PH_MBODY  = 9'b001000000,
    PH_SYXLEN = 9'b010000000,
    PH_SKIP   = 9'b100000000
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_CHAN  = 2'd0;
  localparam logic [1:0] KIND_TEMPO = 2'd1;
  localparam logic [1:0] KIND_SIG   = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  // Status bytes and meta types.
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_MTC      = 8'hF1;
  localparam logic [7:0] ST_SPP      = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] ST_ESCAPE   = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [3:0] HI_PROGRAM  = 4'hC;
  localparam logic [3:0] HI_CHPRESS  = 4'hD;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_TSIG   = 8'h58;
  localparam logic [27:0] TEMPO_LEN    = 28'd3;
  localparam logic [27:0] TSIG_MIN_LEN = 28'd4;

  // Result word, packed so that the tick sits in the lowest bits.
  typedef struct packed {
    logic [7:0]  sig_denom_exp;
    logic [7:0]  sig_numerator;
    logic [23:0] tempo_us;
    logic [7:0]  second_data;
    logic [7:0]  first_data;
    logic [7:0]  status_byte;
    logic [15:0] track_id;
    logic [31:0] tick;
  } result_t;

endpackage

// File: rtl/midi_track_event_parser_top.sv
// Track event parser top level: byte stream in, decoded events out.
// Depends on mtep_pkg.
//
// Usage:
// The input channel (in_*) carries one word per byte of track chunk data.
// in_tuser marks the first byte of a track, which clears the tick and running
// status; in_tlast marks the final byte of the track data. in_tdata carries
// the byte and the index of the track it belongs to.
// The output channel (out_*) carries at most one word per input word: a
// channel event, a tempo change, a time signature, or a flag that the track
// ended inside a delta time. out_tuser gives which of these it is; fields
// that do not belong to that kind read as zero.
// An accepted word waits in the input register while it is parsed, and any
// result it causes is loaded into the output register, which drives the
// output channel. Without stalls, throughput is one word per cycle: the
// input register feeds one pass of parse logic into the output register.
// When the receiver stalls, a waiting result holds in the output register and
// the parser stops; the input register still takes one more word, and
// in_tready drops once both registers are full.
// Reset (synchronous, rst_n low) empties both registers and leaves the parser
// outside any track: bytes are ignored until one arrives with in_tuser set.
module midi_track_event_parser_top
  import mtep_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // [7:0] data_byte, [23:8] track_index
  input  logic         in_tuser,   // first_of_track
  input  logic         in_tlast,   // last_of_track
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // [31:0] tick, [47:32] track_id,
                                   // [55:48] status_byte, [63:56] first_data,
                                   // [71:64] second_data, [95:72] tempo_us,
                                   // [103:96] sig_numerator,
                                   // [111:104] sig_denom_exp
  output logic [1:0]   out_tuser   // kind
);

  // Input register.
  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic [15:0] in_trk_r;
  logic        in_first_r, in_last_r;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic [7:0]  rstat_r, rstat_nxt;
  logic [27:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [27:0] skip_r, skip_nxt;
  logic [7:0]  evst_r, evst_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  mkind_r, mkind_nxt;
  logic [23:0] pay_r, pay_nxt;
  logic        done_r, done_nxt;

  // Output register.
  logic        out_vld_r, out_vld_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  result_t     out_res_r, out_res_nxt;

  // Parse pass signals.
  logic        proc_fire;
  logic        emit;
  phase_t      ph;
  logic [31:0] tick_cur;
  logic [7:0]  rstat_cur;
  logic [27:0] acc_cur;
  logic [1:0]  cnt_cur;
  logic [27:0] skip_cur;
  logic [27:0] skip_dec;
  logic        done_cur;
  logic        vlq_done;
  logic [27:0] vlq_acc;
  logic [7:0]  ev_status;
  logic [7:0]  mk_eff;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [27:0] d);
    logic [32:0] s;
    s = {1'b0, a} + {5'd0, d};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // The parser advances only when the output register can take a result.
  assign proc_fire  = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !in_vld_r || proc_fire;
  assign in_vld_nxt = (in_tvalid && in_tready) ? 1'b1 : (proc_fire ? 1'b0 : in_vld_r);

  // A first-of-track byte restarts the track before it is parsed.
  assign ph        = in_first_r ? PH_DELTA : phase_r;
  assign tick_cur  = in_first_r ? 32'd0 : tick_r;
  assign rstat_cur = in_first_r ? 8'd0 : rstat_r;
  assign acc_cur   = in_first_r ? 28'd0 : acc_r;
  assign cnt_cur   = in_first_r ? 2'd0 : cnt_r;
  assign skip_cur  = in_first_r ? 28'd0 : skip_r;
  assign done_cur  = in_first_r ? 1'b0 : done_r;
  assign skip_dec  = skip_cur - 28'd1;

  // Variable-length quantity step: ends on a clear top bit or the fourth byte.
  assign vlq_done = !in_byte_r[7] || (cnt_cur == 2'd3);
  assign vlq_acc  = {acc_cur[20:0], in_byte_r[6:0]};

  // Channel status for a data byte seen where a status was expected.
  assign ev_status = (ph == PH_STATUS) ? rstat_cur : evst_r;

  // Meta type after the length check; a wrong-length tempo or signature
  // meta is treated as an unknown meta and skipped.
  assign mk_eff = ((mkind_r == META_TEMPO && vlq_acc != TEMPO_LEN) ||
                   (mkind_r == META_TSIG && vlq_acc < TSIG_MIN_LEN)) ? 8'd0 : mkind_r;

  always_comb begin
    phase_nxt = ph;
    tick_nxt  = tick_cur;
    rstat_nxt = rstat_cur;
    acc_nxt   = acc_cur;
    cnt_nxt   = cnt_cur;
    skip_nxt  = skip_cur;
    evst_nxt  = evst_r;
    held_nxt  = held_r;
    mkind_nxt = mkind_r;
    pay_nxt   = pay_r;
    done_nxt  = done_cur;
    emit      = 1'b0;
    out_kind_nxt = KIND_CHAN;
    out_res_nxt  = '0;
    out_res_nxt.tick     = tick_cur;
    out_res_nxt.track_id = in_trk_r;

    if (!done_cur) begin
      case (ph)
        PH_DELTA: begin
          if (vlq_done) begin
            tick_nxt  = sat_add(tick_cur, vlq_acc);
            acc_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_STATUS;
          end else begin
            acc_nxt = vlq_acc;
            cnt_nxt = cnt_cur + 2'd1;
            if (in_last_r) begin
              emit         = 1'b1;
              out_kind_nxt = KIND_TRUNC;
            end
          end
        end
        PH_STATUS, PH_DATA1: begin
          if (ph == PH_STATUS && in_byte_r[7]) begin
            if (in_byte_r < ST_SYSEX) begin
              rstat_nxt = in_byte_r;
              evst_nxt  = in_byte_r;
              phase_nxt = PH_DATA1;
            end else if (in_byte_r == ST_META) begin
              phase_nxt = PH_MTYPE;
            end else if (in_byte_r == ST_SYSEX || in_byte_r == ST_ESCAPE) begin
              acc_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_SYXLEN;
            end else begin
              // Other system messages skip zero, one or two data bytes.
              acc_nxt = '0;
              cnt_nxt = '0;
              if (in_byte_r == ST_MTC || in_byte_r == ST_SONG_SEL) begin
                skip_nxt  = 28'd1;
                phase_nxt = PH_SKIP;
              end else if (in_byte_r == ST_SPP) begin
                skip_nxt  = 28'd2;
                phase_nxt = PH_SKIP;
              end else begin
                skip_nxt  = 28'd0;
                phase_nxt = PH_DELTA;
              end
            end
          end else if (ph == PH_STATUS && rstat_cur == 8'd0) begin
            // Stray data byte with no running status counts as a delta.
            tick_nxt = sat_add(tick_cur, {21'd0, in_byte_r[6:0]});
          end else begin
            evst_nxt = ev_status;
            if (ev_status[7:4] == HI_PROGRAM || ev_status[7:4] == HI_CHPRESS) begin
              emit                    = 1'b1;
              out_res_nxt.status_byte = ev_status;
              out_res_nxt.first_data  = in_byte_r;
              acc_nxt   = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_DELTA;
            end else begin
              held_nxt  = in_byte_r;
              phase_nxt = PH_DATA2;
            end
          end
        end
        PH_DATA2: begin
          emit                    = 1'b1;
          out_res_nxt.status_byte = evst_r;
          out_res_nxt.first_data  = held_r;
          out_res_nxt.second_data = in_byte_r;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_DELTA;
        end
        PH_MTYPE: begin
          mkind_nxt = in_byte_r;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_MLEN;
        end
        PH_MLEN: begin
          if (vlq_done) begin
            mkind_nxt = mk_eff;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            pay_nxt   = '0;
            if (vlq_acc == 28'd0) begin
              if (mk_eff == META_EOT) begin
                done_nxt = 1'b1;
              end
              phase_nxt = PH_DELTA;
            end else begin
              skip_nxt  = vlq_acc;
              phase_nxt = PH_MBODY;
            end
          end else begin
            acc_nxt = vlq_acc;
            cnt_nxt = cnt_cur + 2'd1;
          end
        end
        PH_MBODY: begin
          // The quantity counter doubles as the payload byte position here.
          if (mkind_r == META_TEMPO) begin
            pay_nxt = {pay_r[15:0], in_byte_r};
          end else if (mkind_r == META_TSIG) begin
            if (cnt_cur == 2'd0) begin
              pay_nxt = {8'd0, in_byte_r, pay_r[7:0]};
            end else if (cnt_cur == 2'd1) begin
              pay_nxt = {8'd0, pay_r[15:8], in_byte_r};
            end
          end
          if (cnt_cur != 2'd3) begin
            cnt_nxt = cnt_cur + 2'd1;
          end
          skip_nxt = skip_dec;
          if (skip_dec == 28'd0) begin
            if (mkind_r == META_TEMPO) begin
              emit                 = 1'b1;
              out_kind_nxt         = KIND_TEMPO;
              out_res_nxt.tempo_us = pay_nxt;
            end else if (mkind_r == META_TSIG) begin
              emit                      = 1'b1;
              out_kind_nxt              = KIND_SIG;
              out_res_nxt.sig_numerator = pay_nxt[15:8];
              out_res_nxt.sig_denom_exp = pay_nxt[7:0];
            end else if (mkind_r == META_EOT) begin
              done_nxt = 1'b1;
            end
            acc_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_DELTA;
          end
        end
        PH_SYXLEN: begin
          if (vlq_done) begin
            skip_nxt  = vlq_acc;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = (vlq_acc == 28'd0) ? PH_DELTA : PH_SKIP;
          end else begin
            acc_nxt = vlq_acc;
            cnt_nxt = cnt_cur + 2'd1;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 28'd0) begin
            acc_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_DELTA;
          end
        end
        default: begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_DELTA;
        end
      endcase
    end

    if (in_last_r) begin
      done_nxt = 1'b1;
    end
  end

  assign out_vld_nxt = proc_fire ? emit : (out_vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_DELTA;
      tick_r    <= '0;
      rstat_r   <= '0;
      acc_r     <= '0;
      cnt_r     <= '0;
      skip_r    <= '0;
      evst_r    <= '0;
      held_r    <= '0;
      mkind_r   <= '0;
      pay_r     <= '0;
      done_r    <= 1'b1;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (proc_fire) begin
        phase_r <= phase_nxt;
        tick_r  <= tick_nxt;
        rstat_r <= rstat_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
        skip_r  <= skip_nxt;
        evst_r  <= evst_nxt;
        held_r  <= held_nxt;
        mkind_r <= mkind_nxt;
        pay_r   <= pay_nxt;
        done_r  <= done_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata[7:0];
      in_trk_r   <= in_tdata[23:8];
      in_first_r <= in_tuser;
      in_last_r  <= in_tlast;
    end
    if (proc_fire && emit) begin
      out_kind_r <= out_kind_nxt;
      out_res_r  <= out_res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r;
  assign out_tuser  = out_kind_r;

endmodule

// File: tb/midi_track_event_parser_top_tb.sv
// Self-checking testbench for midi_track_event_parser_top: streams track bytes,
// predicts every decoded event in place and checks each output word against it.
// Depends on mtep_pkg and the parser RTL.
module midi_track_event_parser_top_tb
  import mtep_pkg::*;
();

  // One input word as queued for the driver, with pacing hints attached.
  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] track;
    bit          calm;   // no idling on either side while this word is sent
    bit          drain;  // hold this word back until every expected event is out
  } track_byte_t;

  // One expected output word: kind on out_tuser, fields on out_tdata.
  typedef struct packed {
    logic [1:0] kind;
    result_t    body;
  } event_rec_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata = '0;   // [7:0] data_byte, [23:8] track_index
  logic         in_tuser = 1'b0; // first_of_track
  logic         in_tlast = 1'b0; // last_of_track
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;       // tick, track_id, status, data 1, data 2, tempo, num, denom
  logic [1:0]   out_tuser;       // kind

  midi_track_event_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard storage.
  track_byte_t byte_feed[$];      // words waiting for the driver
  event_rec_t  pending_events[$]; // decoded events not yet seen on the output
  logic [7:0]  trk_bytes[$];      // the track under construction
  logic [7:0]  gen_status = '0;   // running status as the generator sees it

  int unsigned bytes_sent = 0;
  int unsigned total_bytes = 0;
  int unsigned bytes_in_tracks = 0;
  int unsigned tracks_built = 0;
  int unsigned events_checked = 0;
  int unsigned mismatches = 0;
  int unsigned kind_count[4] = '{0, 0, 0, 0};
  bit          quiet = 1'b0;      // the word on the bus asked for no idling

  // Queue helpers.
  task automatic put_byte(logic [7:0] b);
    trk_bytes.insert(trk_bytes.size(), b);
  endtask

  task automatic queue_word(track_byte_t w);
    byte_feed.insert(byte_feed.size(), w);
  endtask

  task automatic note_event(event_rec_t ev);
    pending_events.insert(pending_events.size(), ev);
  endtask

  // ---------------------------------------------------------------------------
  // Parser state as the testbench tracks it. The decode below mirrors the
  // intended behavior: a delta-time quantity first, then a status byte (or a
  // data byte under running status), then the body of the event.
  // ---------------------------------------------------------------------------
  phase_t      ph;
  logic [31:0] abs_tick;
  logic [7:0]  run_status;
  logic [27:0] qty;
  logic [1:0]  qty_cnt;
  logic [27:0] skip_left;
  logic [7:0]  ev_status;
  logic [7:0]  held_d1;
  logic [7:0]  meta_type;
  logic [23:0] capture;
  logic        outside;

  function automatic void qty_clear();
    qty = '0;
    qty_cnt = '0;
  endfunction

  // The tick never wraps; it sticks at all ones.
  function automatic void bump_tick(logic [31:0] d);
    logic [32:0] s;
    s = {1'b0, abs_tick} + {1'b0, d};
    abs_tick = s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // A quantity ends on a byte with a clear top bit, or on its fourth byte anyway.
  function automatic bit qty_take(logic [7:0] b);
    bit done;
    done = !b[7] || (qty_cnt == 2'd3);
    qty = {qty[20:0], b[6:0]};
    if (!done) qty_cnt = qty_cnt + 2'd1;
    return done;
  endfunction

  function automatic void begin_skip(logic [27:0] n);
    skip_left = n;
    ph = (n == 0) ? PH_DELTA : PH_SKIP;
    qty_clear();
  endfunction

  function automatic event_rec_t blank_event(logic [1:0] kind, logic [15:0] trk);
    event_rec_t ev;
    ev = '0;
    ev.kind = kind;
    ev.body.tick = abs_tick;
    ev.body.track_id = trk;
    return ev;
  endfunction

  function automatic event_rec_t channel_event(logic [7:0] d1, logic [7:0] d2,
                                               logic [15:0] trk);
    event_rec_t ev;
    ev = blank_event(KIND_CHAN, trk);
    ev.body.status_byte = ev_status;
    ev.body.first_data = d1;
    ev.body.second_data = d2;
    ph = PH_DELTA;
    qty_clear();
    return ev;
  endfunction

  // Program change and channel pressure finish on their only data byte.
  function automatic bit take_first_data(logic [7:0] b, logic [15:0] trk,
                                         output event_rec_t ev);
    ev = '0;
    if (ev_status[7:4] == HI_PROGRAM || ev_status[7:4] == HI_CHPRESS) begin
      ev = channel_event(b, 8'h00, trk);
      return 1'b1;
    end
    held_d1 = b;
    ph = PH_DATA2;
    return 1'b0;
  endfunction

  // Advances the tracked parser by one accepted word; returns 1 with the event
  // that the word completes, if any.
  function automatic bit parse_track_byte(track_byte_t w, output event_rec_t ev);
    bit          got;
    logic [7:0]  b;
    logic [27:0] len;
    got = 1'b0;
    b = w.data;
    ev = '0;
    if (w.first) begin
      ph = PH_DELTA;
      abs_tick = '0;
      run_status = '0;
      qty_clear();
      skip_left = '0;
      outside = 1'b0;
    end
    if (outside) return 1'b0;
    case (ph)
      PH_DELTA: begin
        if (qty_take(b)) begin
          bump_tick({4'h0, qty});
          qty_clear();
          ph = PH_STATUS;
        end else if (w.last) begin
          // Track cut off while the delta still wanted more bytes.
          ev = blank_event(KIND_TRUNC, w.track);
          got = 1'b1;
        end
      end
      PH_STATUS: begin
        if (!b[7]) begin
          if (run_status != 0) begin
            ev_status = run_status;
            got = take_first_data(b, w.track, ev);
          end else begin
            // No running status: the stray byte counts as a one-byte delta.
            bump_tick({24'h0, b});
          end
        end else if (b < ST_SYSEX) begin
          run_status = b;
          ev_status = b;
          ph = PH_DATA1;
        end else if (b == ST_META) begin
          ph = PH_MTYPE;
        end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
          qty_clear();
          ph = PH_SYXLEN;
        end else if (b == ST_MTC || b == ST_SONG_SEL) begin
          begin_skip(28'd1);
        end else if (b == ST_SPP) begin
          begin_skip(28'd2);
        end else begin
          begin_skip(28'd0);
        end
      end
      PH_DATA1: got = take_first_data(b, w.track, ev);
      PH_DATA2: begin
        ev = channel_event(held_d1, b, w.track);
        got = 1'b1;
      end
      PH_MTYPE: begin
        meta_type = b;
        qty_clear();
        ph = PH_MLEN;
      end
      PH_MLEN: begin
        if (qty_take(b)) begin
          len = qty;
          if ((meta_type == META_TEMPO && len != TEMPO_LEN) ||
              (meta_type == META_TSIG && len < TSIG_MIN_LEN)) meta_type = '0;
          qty_clear();
          capture = '0;
          if (len == 0) begin
            if (meta_type == META_EOT) outside = 1'b1;
            ph = PH_DELTA;
          end else begin
            skip_left = len;
            ph = PH_MBODY;
          end
        end
      end
      PH_MBODY: begin
        if (meta_type == META_TEMPO) begin
          capture = {capture[15:0], b};
        end else if (meta_type == META_TSIG) begin
          if (qty_cnt == 2'd0) capture = {8'h00, b, capture[7:0]};
          else if (qty_cnt == 2'd1) capture = {8'h00, capture[15:8], b};
        end
        if (qty_cnt < 2'd3) qty_cnt = qty_cnt + 2'd1;
        skip_left = skip_left - 28'd1;
        if (skip_left == 0) begin
          if (meta_type == META_TEMPO) begin
            ev = blank_event(KIND_TEMPO, w.track);
            ev.body.tempo_us = capture;
            got = 1'b1;
          end else if (meta_type == META_TSIG) begin
            ev = blank_event(KIND_SIG, w.track);
            ev.body.sig_numerator = capture[15:8];
            ev.body.sig_denom_exp = capture[7:0];
            got = 1'b1;
          end else if (meta_type == META_EOT) begin
            outside = 1'b1;
          end
          qty_clear();
          ph = PH_DELTA;
        end
      end
      PH_SYXLEN: begin
        if (qty_take(b)) begin_skip(qty);
      end
      PH_SKIP: begin
        skip_left = skip_left - 28'd1;
        if (skip_left == 0) begin
          qty_clear();
          ph = PH_DELTA;
        end
      end
      default: begin
        ph = PH_DELTA;
        qty_clear();
      end
    endcase
    if (w.last) outside = 1'b1;
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // Track builders. Each appends bytes to trk_bytes; flush_track turns the
  // finished track into words for the driver.
  // ---------------------------------------------------------------------------
  task automatic put_qty(int unsigned v, bit pad);
    logic [6:0] grp[4];
    int         n;
    n = 0;
    do begin
      grp[n] = v[6:0];
      v = v >> 7;
      n++;
    end while (v != 0 && n < 4);
    // Leading zero groups are legal and stretch the quantity to four bytes.
    if (pad) while (n < 4) begin
      grp[n] = 7'h00;
      n++;
    end
    for (int i = n - 1; i >= 0; i--) put_byte({i != 0, grp[i]});
  endtask

  task automatic put_delta(bit huge);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (huge) begin
      put_qty(32'h0FFF_FFFF, 1'b0);
    end else if (pick == 0) begin
      // Four bytes all with the top bit set: the quantity ends anyway.
      repeat (4) put_byte({1'b1, 7'($urandom_range(0, 127))});
    end else if (pick == 1) begin
      put_qty($urandom_range(0, 28'hFFF_FFFF), 1'b0);
    end else if (pick < 4) begin
      put_qty($urandom_range(0, 127), 1'b1);
    end else if (pick < 7) begin
      put_qty($urandom_range(128, 16383), 1'b0);
    end else if (pick < 11) begin
      put_qty(0, 1'b0);
    end else begin
      put_qty($urandom_range(0, 127), 1'b0);
    end
  endtask

  task automatic put_event();
    int unsigned what;
    int unsigned len;
    logic [7:0]  st;
    what = $urandom_range(0, 99);
    if (what < 45) begin
      st = 8'($urandom_range(8'h80, 8'hEF));
      if (gen_status != 0 && $urandom_range(0, 2) == 0) begin
        st = gen_status;   // lean on running status
      end else begin
        put_byte(st);
        gen_status = st;
      end
      put_byte(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 127)));
      if (st[7:4] != HI_PROGRAM && st[7:4] != HI_CHPRESS)
        put_byte(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 127)));
    end else if (what < 55) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 3;
      put_byte(ST_META);
      put_byte(META_TEMPO);
      put_qty(len, $urandom_range(0, 7) == 0);
      repeat (len) put_byte(8'($urandom_range(0, 255)));
    end else if (what < 63) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 6);
      put_byte(ST_META);
      put_byte(META_TSIG);
      put_qty(len, $urandom_range(0, 7) == 0);
      repeat (len) put_byte(8'($urandom_range(0, 255)));
    end else if (what < 70) begin
      st = 8'($urandom_range(0, 255));
      if (st == META_EOT) st = 8'h01;
      len = $urandom_range(0, 4);
      put_byte(ST_META);
      put_byte(st);
      put_qty(len, $urandom_range(0, 7) == 0);
      repeat (len) put_byte(8'($urandom_range(0, 255)));
    end else if (what < 77) begin
      len = $urandom_range(0, 5);
      put_byte($urandom_range(0, 1) ? ST_SYSEX : ST_ESCAPE);
      put_qty(len, $urandom_range(0, 7) == 0);
      repeat (len) put_byte(8'($urandom_range(0, 255)));
    end else if (what < 85) begin
      case ($urandom_range(0, 2))
        0: put_byte(ST_MTC);
        1: put_byte(ST_SONG_SEL);
        default: begin
          put_byte(ST_SPP);
          put_byte(8'($urandom_range(0, 127)));
        end
      endcase
      put_byte(8'($urandom_range(0, 127)));
    end else if (what < 92) begin
      put_byte(8'($urandom_range(8'hF4, 8'hFE)));
    end else if (what < 96) begin
      if (gen_status == 0) put_byte(8'($urandom_range(0, 127)));
    end else begin
      // Raw garbage in the middle of a track.
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic flush_track(logic [15:0] idx, bit mark_last, bit calm, bit drain);
    track_byte_t w;
    for (int i = 0; i < trk_bytes.size(); i++) begin
      w.data = trk_bytes[i];
      w.first = (i == 0);
      w.last = mark_last && (i == trk_bytes.size() - 1);
      w.track = idx;
      w.calm = calm;
      w.drain = drain && (i == 0);
      queue_word(w);
    end
    bytes_in_tracks += trk_bytes.size();
    tracks_built++;
    trk_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents one word at a time from byte_feed, with random idle bursts
  // and, where a word asks for it, a hold-off until the output has drained.
  // Each word is run through the tracked parser on the edge that accepts it.
  // ---------------------------------------------------------------------------
  track_byte_t cur_byte;
  int unsigned send_gap = 0;

  always @(posedge clk) begin
    event_rec_t ev;
    bit         nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (parse_track_byte(cur_byte, ev)) note_event(ev);
        bytes_sent++;
      end
      // Only move on once the word on the bus, if any, has been taken.
      if (!in_tvalid || in_tready) begin
        nv = 1'b0;
        if (send_gap != 0) begin
          send_gap--;
        end else if (byte_feed.size() != 0) begin
          if (byte_feed[0].drain && pending_events.size() != 0) begin
            // Wait for every outstanding event before this track starts.
          end else if (!byte_feed[0].calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 14) - 1;
          end else begin
            cur_byte = byte_feed.pop_front();
            nv = 1'b1;
            in_tdata <= {cur_byte.track, cur_byte.data};
            in_tuser <= cur_byte.first;
            in_tlast <= cur_byte.last;
            quiet <= cur_byte.calm;
          end
        end
        in_tvalid <= nv;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every word taken from the output is matched against the oldest
  // expected event, field by field. out_tready stalls in random bursts.
  // ---------------------------------------------------------------------------
  task automatic check_field(string label, logic [31:0] want, logic [31:0] seen,
                             inout bit bad);
    if (want !== seen) begin
      if (mismatches < 10)
        $display("[%0t] %s mismatch: expected %h, got %h", $realtime, label, want, seen);
      bad = 1'b1;
    end
  endtask

  int unsigned ready_gap = 0;

  always @(posedge clk) begin
    event_rec_t want;
    result_t    seen;
    bit         bad;
    bit         nr;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (pending_events.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected event: kind %0d tick %0d track %0d",
                     $realtime, out_tuser, seen.tick, seen.track_id);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          events_checked++;
          kind_count[want.kind]++;
          bad = 1'b0;
          check_field("kind", 32'(want.kind), 32'(out_tuser), bad);
          check_field("tick", want.body.tick, seen.tick, bad);
          check_field("track_id", 32'(want.body.track_id), 32'(seen.track_id), bad);
          check_field("status_byte", 32'(want.body.status_byte),
                      32'(seen.status_byte), bad);
          check_field("first_data", 32'(want.body.first_data),
                      32'(seen.first_data), bad);
          check_field("second_data", 32'(want.body.second_data),
                      32'(seen.second_data), bad);
          check_field("tempo_us", 32'(want.body.tempo_us), 32'(seen.tempo_us), bad);
          check_field("sig_numerator", 32'(want.body.sig_numerator),
                      32'(seen.sig_numerator), bad);
          check_field("sig_denom_exp", 32'(want.body.sig_denom_exp),
                      32'(seen.sig_denom_exp), bad);
          if (bad) mismatches++;
        end
      end
      nr = 1'b1;
      if (ready_gap != 0) begin
        ready_gap--;
        nr = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        ready_gap = $urandom_range(1, 14) - 1;
        nr = 1'b0;
      end
      out_tready <= nr;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    track_byte_t stray;
    int unsigned ending;
    int unsigned nev;
    int unsigned keep;
    bit          huge;
    bit          calm_trk;
    bit          mark_last;

    ph = PH_DELTA;
    abs_tick = '0;
    run_status = '0;
    qty = '0;
    qty_cnt = '0;
    skip_left = '0;
    ev_status = '0;
    held_d1 = '0;
    meta_type = '0;
    capture = '0;
    outside = 1'b1;

    // Directed part. A byte before any track start must be ignored.
    stray = '{data: 8'hFF, first: 1'b0, last: 1'b0, track: 16'h0000,
              calm: 1'b0, drain: 1'b0};
    queue_word(stray);
    // Note on, a two-byte delta with program change, channel pressure at
    // extreme data values, then a tempo and a time signature closing the track.
    trk_bytes = '{8'h00, 8'h90, 8'h3C, 8'h64,
                  8'h81, 8'h00, {HI_PROGRAM, 4'h5}, 8'h7F,
                  8'h00, {HI_CHPRESS, 4'h3}, 8'h00,
                  8'h00, ST_META, META_TEMPO, 8'h03, 8'h07, 8'hA1, 8'h20,
                  8'h00, ST_META, META_TSIG, 8'h04, 8'h06, 8'h03, 8'h18, 8'h08};
    flush_track(16'hFFFF, 1'b1, 1'b0, 1'b0);
    // A track that stops in the middle of its first delta time.
    trk_bytes = '{8'h80, 8'h80};
    flush_track(16'h0000, 1'b1, 1'b0, 1'b0);

    // Random part: mostly well-formed tracks with random content, with the
    // odd truncation, restart, stray byte between tracks and garbage inside.
    while (bytes_in_tracks < 385) begin
      gen_status = '0;
      huge = (tracks_built == 4) || ($urandom_range(0, 24) == 0);
      calm_trk = ($urandom_range(0, 4) == 0);
      nev = huge ? 20 : $urandom_range(1, 8);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          stray.data = 8'($urandom_range(0, 255));
          stray.track = 16'($urandom_range(0, 16'hFFFF));
          queue_word(stray);
        end
      end
      repeat (nev) begin
        put_delta(huge);
        put_event();
      end
      ending = $urandom_range(0, 9);
      mark_last = 1'b1;
      if (ending < 5) begin
        put_byte(8'h00);
        put_byte(ST_META);
        put_byte(META_EOT);
        if ($urandom_range(0, 5) == 0) begin
          put_byte(8'h01);
          put_byte(8'($urandom_range(0, 255)));
        end else begin
          put_byte(8'h00);
        end
      end else if (ending == 5) begin
        // End of track, then trailing bytes the parser must ignore.
        put_byte(8'h00);
        put_byte(ST_META);
        put_byte(META_EOT);
        put_byte(8'h00);
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
      end else if (ending == 6) begin
        repeat ($urandom_range(1, 3)) put_byte({1'b1, 7'($urandom_range(0, 127))});
      end else if (ending == 7) begin
        keep = $urandom_range(1, trk_bytes.size());
        while (trk_bytes.size() > keep) void'(trk_bytes.pop_back());
      end else begin
        // No last flag: the next track start cuts this one off.
        mark_last = 1'b0;
      end
      flush_track(16'($urandom_range(0, 16'hFFFF)), mark_last, calm_trk,
                  (tracks_built == 2) || (tracks_built % 8 == 0));
    end
    // The tail of the run goes without any idling.
    for (int i = byte_feed.size() - 60; i < byte_feed.size(); i++)
      if (i >= 0) byte_feed[i].calm = 1'b1;
    total_bytes = byte_feed.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_sent != total_bytes) @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    // Let any late or spurious word surface after the last expected one.
    repeat (10) @(posedge clk);

    $display("Sent %0d words in %0d tracks; checked %0d events.",
             total_bytes, tracks_built, events_checked);
    $display("Events by kind: channel %0d, tempo %0d, time signature %0d, open delta %0d.",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d events never seen", mismatches, pending_events.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: midi_track_event_parser_top.f
rtl/mtep_pkg.sv
rtl/midi_track_event_parser_top.sv
tb/midi_track_event_parser_top_tb.sv
